[hdl/fse_pkg.sv]
// ----------------------------------------------------------------------------
// Fire ellipse shape package
// Fixed-point constants of the fire-front ellipse pipeline, including the
// reciprocal multipliers for the truncating divides of the exponential series.
// ----------------------------------------------------------------------------
package fse_pkg;

  localparam logic [15:0] WIND_MAX    = 16'd40960;     // 40.0 in Q6.10
  localparam logic [24:0] ONE_Q24     = 25'd16777216;
  localparam logic [30:0] K_GROW      = 31'd1589977770; // 0.2566 / ln2, Q0.32
  localparam logic [29:0] K_DECAY     = 30'd959191577;  // 0.1548 / ln2, Q0.32
  localparam logic [31:0] LN2_Q32     = 32'd2977044472;
  localparam logic [23:0] COEF_GROW   = 24'd15703474;   // 0.936, Q0.24
  localparam logic [22:0] COEF_DECAY  = 23'd7734297;    // 0.461, Q0.24
  localparam logic [22:0] COEF_OFFSET = 23'd6660555;    // 0.397, Q0.24

  // Reciprocal multipliers ceil(2^(32+l) / d) for the odd part d of each divisor.
  localparam logic [32:0] M_O1  = 33'(64'd1 << 32);
  localparam logic [32:0] M_O3  = 33'(((64'd1 << 34) + 64'd2) / 64'd3);
  localparam logic [32:0] M_O5  = 33'(((64'd1 << 35) + 64'd4) / 64'd5);
  localparam logic [32:0] M_O7  = 33'(((64'd1 << 35) + 64'd6) / 64'd7);
  localparam logic [32:0] M_O9  = 33'(((64'd1 << 36) + 64'd8) / 64'd9);
  localparam logic [32:0] M_O11 = 33'(((64'd1 << 36) + 64'd10) / 64'd11);
  localparam logic [32:0] M_O13 = 33'(((64'd1 << 36) + 64'd12) / 64'd13);
  localparam logic [32:0] M_O15 = 33'(((64'd1 << 36) + 64'd14) / 64'd15);

  // Entry n serves the series divisor n+1: pre-shift, multiplier, post-shift.
  localparam logic [2:0] DIV_TZ [16] = '{
    3'd0, 3'd1, 3'd0, 3'd2, 3'd0, 3'd1, 3'd0, 3'd3,
    3'd0, 3'd1, 3'd0, 3'd2, 3'd0, 3'd1, 3'd0, 3'd4
  };
  localparam logic [32:0] DIV_M [16] = '{
    M_O1, M_O1, M_O3, M_O1, M_O5, M_O3, M_O7, M_O1,
    M_O9, M_O5, M_O11, M_O3, M_O13, M_O7, M_O15, M_O1
  };
  localparam logic [5:0] DIV_SH [16] = '{
    6'd32, 6'd32, 6'd34, 6'd32, 6'd35, 6'd34, 6'd35, 6'd32,
    6'd36, 6'd35, 6'd36, 6'd34, 6'd36, 6'd35, 6'd36, 6'd32
  };

endpackage

[hdl/fire_spread_ellipse_shape_core.sv]
// ----------------------------------------------------------------------------
// Fire-front ellipse shape core
// Turns a head spread rate and a wind speed into the ellipse parameters a, b
// and c of the length-to-breadth fire shape model.
// ----------------------------------------------------------------------------
// Usage: a request is taken at a rising edge where start is high and busy is
// low. Each request gives exactly one result, shown on the ellipse and
// wind_clamped_o ports for one cycle while done_o is high. Requests may
// follow in every cycle, so the core sustains one request per clock;
// results leave in request order. Each request runs through a chain of
// iterative units: the 16-term exponential series (two stages a term),
// the 25-stage reciprocal divider, the 32-stage square roots and the
// 24-stage output dividers, each one bit or one term per stage.
// busy is high during reset and in the first cycle after it, then stays low.
// Reset clears the valid bits of every stage, so no result appears until a
// request has gone through. The receiver cannot stall: it must take each
// result in the cycle in which done_o is high.
// ----------------------------------------------------------------------------
module fire_spread_ellipse_shape_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [23:0] spread_rate_i,
  input  logic [15:0] wind_speed_i,
  output logic        done_o,
  output logic [23:0] ellipse_a_o,
  output logic [23:0] ellipse_b_o,
  output logic [23:0] ellipse_c_o,
  output logic        wind_clamped_o
);

  localparam int unsigned LAT = 123;

  logic        busy_q;
  logic        accept;
  logic [15:0] uc;
  logic        clamp;

  logic        v_q   [1:LAT];
  logic [24:0] sb_q  [1:LAT];

  logic [35:0] y_q   [2];
  logic [31:0] f_q   [2][2:32];
  logic [3:0]  n_q   [2][2:34];
  logic [31:0] wk_q  [2][3:33];
  logic [33:0] sm_q  [2][3:34];
  logic [31:0] tq    [2][16];
  logic [40:0] ex    [2];

  logic [38:0] eg_q  [35:60];
  logic [32:0] dv_q  [35:59];
  logic [48:0] rr_q  [35:60];
  logic [24:0] qr_q  [35:60];

  logic [62:0] pp1_q;
  logic [47:0] pp2_q;
  logic [39:0] t_q;
  logic [38:0] lbc_q [63:97];
  logic [62:0] sqr_q [2][64:96];
  logic [31:0] sqt_q [2][64:96];
  logic [39:0] s_q;
  logic [39:0] p_q   [98:122];
  logic [62:0] mb_q;
  logic [63:0] mc_q;
  logic [63:0] dr_q  [3][99:123];
  logic [23:0] dq_q  [3][99:123];

  assign busy   = busy_q;
  assign accept = start & ~busy_q;
  assign clamp  = (wind_speed_i > fse_pkg::WIND_MAX);
  assign uc     = clamp ? fse_pkg::WIND_MAX : wind_speed_i;

  // Truncating divide of each series term by its index, by reciprocal multiply.
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      for (int jj = 0; jj < 16; jj++) begin
        tq[l][jj] = 32'(((65'(wk_q[l][2*jj+3]) >> fse_pkg::DIV_TZ[jj])
                         * 65'(fse_pkg::DIV_M[jj])) >> fse_pkg::DIV_SH[jj]);
      end
      ex[l] = 41'(((49'(sm_q[l][34]) << n_q[l][34]) + 49'd128) >> 8);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      for (int k = 1; k <= LAT; k++) begin
        v_q[k] <= 1'b0;
      end
    end else begin
      busy_q <= 1'b0;
      v_q[1] <= accept;
      for (int k = 2; k <= LAT; k++) begin
        v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    // Side band: rate and clamp flag travel with the request.
    sb_q[1] <= {clamp, spread_rate_i};
    for (int k = 2; k <= LAT; k++) begin
      sb_q[k] <= sb_q[k-1];
    end

    // Exponent in base two, split into integer and fraction.
    y_q[0] <= 36'((48'(fse_pkg::K_GROW) * 48'(uc) + 48'd512) >> 10);
    y_q[1] <= 36'((48'(fse_pkg::K_DECAY) * 48'(uc) + 48'd512) >> 10);
    for (int l = 0; l < 2; l++) begin
      f_q[l][2] <= 32'((65'(y_q[l][31:0]) * 65'(fse_pkg::LN2_Q32) + (65'd1 << 31)) >> 32);
      n_q[l][2] <= y_q[l][35:32];
      for (int k = 3; k <= 32; k++) begin
        f_q[l][k] <= f_q[l][k-1];
      end
      for (int k = 3; k <= 34; k++) begin
        n_q[l][k] <= n_q[l][k-1];
      end

      // Series for e^f: a multiply stage and a divide stage per term.
      wk_q[l][3] <= f_q[l][2];
      sm_q[l][3] <= 34'd1 << 32;
      for (int jj = 1; jj < 16; jj++) begin
        wk_q[l][2*jj+3] <= 32'((64'(wk_q[l][2*jj+2]) * 64'(f_q[l][2*jj+2])) >> 32);
        sm_q[l][2*jj+3] <= sm_q[l][2*jj+2];
      end
      for (int jj = 0; jj < 15; jj++) begin
        wk_q[l][2*jj+4] <= tq[l][jj];
      end
      for (int jj = 0; jj < 16; jj++) begin
        sm_q[l][2*jj+4] <= sm_q[l][2*jj+3] + 34'(tq[l][jj]);
      end
    end

    // Scale back by the integer part; set up the reciprocal divide.
    eg_q[35] <= ex[0][38:0];
    dv_q[35] <= ex[1][32:0];
    rr_q[35] <= (49'd1 << 48) + 49'(ex[1][32:1]);
    qr_q[35] <= '0;
    for (int k = 36; k <= 60; k++) begin
      eg_q[k] <= eg_q[k-1];
      if ((58'(rr_q[k-1])) >= (58'(dv_q[k-1]) << (60 - k))) begin
        rr_q[k] <= 49'(58'(rr_q[k-1]) - (58'(dv_q[k-1]) << (60 - k)));
        qr_q[k] <= qr_q[k-1] | (25'd1 << (60 - k));
      end else begin
        rr_q[k] <= rr_q[k-1];
        qr_q[k] <= qr_q[k-1];
      end
    end
    for (int k = 36; k <= 59; k++) begin
      dv_q[k] <= dv_q[k-1];
    end

    // Length-to-breadth ratio, saturated at one.
    pp1_q <= 63'(eg_q[60]) * 63'(fse_pkg::COEF_GROW);
    pp2_q <= 48'(qr_q[60]) * 48'(fse_pkg::COEF_DECAY);
    t_q   <= 40'((64'(pp1_q) + 64'(pp2_q) + (64'd1 << 23)) >> 24);
    lbc_q[63] <= (t_q < (40'(fse_pkg::COEF_OFFSET) + 40'(fse_pkg::ONE_Q24)))
                 ? 39'(fse_pkg::ONE_Q24) : 39'(t_q - 40'(fse_pkg::COEF_OFFSET));
    for (int k = 64; k <= 97; k++) begin
      lbc_q[k] <= lbc_q[k-1];
    end

    // Square roots of (LB - 1) and (LB + 1), one root bit per stage.
    sqr_q[0][64] <= 63'(lbc_q[63] - 39'(fse_pkg::ONE_Q24)) << 24;
    sqr_q[1][64] <= 63'(40'(lbc_q[63]) + 40'(fse_pkg::ONE_Q24)) << 24;
    for (int l = 0; l < 2; l++) begin
      sqt_q[l][64] <= '0;
      for (int k = 65; k <= 96; k++) begin
        if (65'(sqr_q[l][k-1]) >= ((65'(sqt_q[l][k-1]) << (97 - k))
                                   + (65'd1 << (2 * (96 - k))))) begin
          sqr_q[l][k] <= 63'(65'(sqr_q[l][k-1]) - ((65'(sqt_q[l][k-1]) << (97 - k))
                                                   + (65'd1 << (2 * (96 - k)))));
          sqt_q[l][k] <= sqt_q[l][k-1] | (32'd1 << (96 - k));
        end else begin
          sqr_q[l][k] <= sqr_q[l][k-1];
          sqt_q[l][k] <= sqt_q[l][k-1];
        end
      end
    end

    s_q <= 40'((65'(sqt_q[0][96]) * 65'(sqt_q[1][96]) + (65'd1 << 23)) >> 24);

    // Common denominator and the three rounded dividends.
    p_q[98] <= 40'(lbc_q[97]) + s_q;
    mb_q    <= 63'(sb_q[97][23:0]) * 63'(lbc_q[97]);
    mc_q    <= 64'(sb_q[97][23:0]) * 64'(s_q);
    for (int k = 99; k <= 122; k++) begin
      p_q[k] <= p_q[k-1];
    end
    dr_q[0][99] <= (64'(sb_q[98][23:0]) << 24) + 64'(p_q[98][39:1]);
    dr_q[1][99] <= 64'(mb_q) + 64'(p_q[98][39:1]);
    dr_q[2][99] <= mc_q + 64'(p_q[98][39:1]);
    for (int l = 0; l < 3; l++) begin
      dq_q[l][99] <= '0;
      for (int k = 100; k <= 123; k++) begin
        if (dr_q[l][k-1] >= (64'(p_q[k-1]) << (123 - k))) begin
          dr_q[l][k] <= dr_q[l][k-1] - (64'(p_q[k-1]) << (123 - k));
          dq_q[l][k] <= dq_q[l][k-1] | (24'd1 << (123 - k));
        end else begin
          dr_q[l][k] <= dr_q[l][k-1];
          dq_q[l][k] <= dq_q[l][k-1];
        end
      end
    end
  end

  assign done_o         = v_q[LAT];
  assign ellipse_a_o    = dq_q[0][LAT];
  assign ellipse_b_o    = dq_q[1][LAT];
  assign ellipse_c_o    = dq_q[2][LAT];
  assign wind_clamped_o = sb_q[LAT][24];

  // Once out of reset the core never holds requests off.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !busy |=> !busy)
    else $error("busy rose after reset");

  // The reciprocal of a growth factor of at least one stays at or below one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   v_q[60] |-> (qr_q[60] <= 25'(fse_pkg::ONE_Q24)))
    else $error("reciprocal exceeds one");

  // The ratio is saturated, so it never drops below one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   v_q[64] |-> (40'(lbc_q[64]) >= 40'(fse_pkg::ONE_Q24)))
    else $error("length-to-breadth ratio below one");

  // a <= b and c <= b, because LB is at least one and at least s.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   done_o |-> (ellipse_a_o <= ellipse_b_o) && (ellipse_c_o <= ellipse_b_o))
    else $error("ellipse parameters out of order");

endmodule
